// File: rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants of the linear probe hash table
// Holds the command, status and slot mark codes, the write enable group and
// the controller state type.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam logic [1:0] CMD_SET    = 2'd0;
	localparam logic [1:0] CMD_GET    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	localparam logic [1:0] MARK_EMPTY = 2'd0;
	localparam logic [1:0] MARK_USED  = 2'd1;
	localparam logic [1:0] MARK_TOMB  = 2'd2;

	localparam logic [31:0] FIB_MUL = 32'd2654435769;
	localparam int COUNT_W = 11;
	localparam int MIN_COMPACT_SLOTS = 16;

	typedef struct packed {
		logic key;
		logic val;
		logic mark;
	} mem_we_t;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_HASH, S_HOME, S_PRD, S_PCHK, S_ACT, S_CLR,
		S_RB_CLR, S_RB_RD, S_RB_CHK, S_RB_HASH, S_RB_HOME, S_RB_PRD,
		S_RB_PCHK, S_RB_WR, S_DONE
	} state_t;

endpackage

// File: rtl/linear_probe_hash_table_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit: open-addressing map of 32-bit keys to values
// Set, get, remove and clear over a linear-probe table with two banks.
// ----------------------------------------------------------------------------
// One beat in, one beat out. A get, set or remove hashes the key, takes its
// home slot and probes from there: each probe is a read of the slot memory
// followed by a look at the registered read data; then it acts and returns
// the result. A clear sweeps the active bank. A rebuild (before a set at three
// quarters load, or after a remove that leaves many tombstones) sweeps the
// spare bank marks, then walks every source slot and re-inserts each live
// entry. After reset a clearing pass empties all slot marks; s_tready stays
// low meanwhile. Results wait in an output register, so the next command is
// taken while a result beat is still held.
module linear_probe_hash_table_unit #(
	parameter int TABLE_SLOTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // key [31:0], value [63:32]
	input  logic [1:0]  s_tuser,   // cmd [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // status [1:0], found [2], read_value [34:3],
	                               // entry_count [45:35], zero [47:46]
);
	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int CW = AW + 1;
	localparam int THREE_Q = 3 * TABLE_SLOTS;
	localparam bit CAN_COMPACT = TABLE_SLOTS > lpht_pkg::MIN_COMPACT_SLOTS;

	lpht_pkg::state_t state_q, state_d;

	// command registers
	logic [1:0]    cmd_q;
	logic [31:0]   key_q, val_q;
	// probe state
	logic [AW-1:0] slot_q, tomb_slot_q, where_q;
	logic [AW-1:0] n_q;
	logic          have_tomb_q, found_q, room_q;
	// sweep counter, wide enough for both banks
	logic [AW:0]   cnt_q;
	logic          bank_q, rb_ret_q;
	logic [CW-1:0] live_q, tomb_q;
	logic [31:0]   rb_key_q, rb_val_q;
	// result registers
	logic [1:0]    res_status_q;
	logic          res_found_q;
	logic [31:0]   res_rv_q;
	logic          out_valid_q;
	logic [47:0]   out_data_q;

	logic [AW-1:0] home;
	logic [31:0]   hkey;
	logic [AW:0]   rd_addr, wr_addr;
	logic [31:0]   rd_key, rd_val, wr_key, wr_val;
	logic [1:0]    rd_mark, wr_mark;
	lpht_pkg::mem_we_t we;

	// next-value wires of the control registers
	logic [AW-1:0] slot_d, tomb_slot_d, where_d, n_d;
	logic          have_tomb_d, found_d, room_d, bank_d, rb_ret_d;
	logic [AW:0]   cnt_d;
	logic [CW-1:0] live_d, tomb_d;
	logic [1:0]    res_status_d;
	logic [31:0]   res_rv_d;
	logic          load_out, latch_cmd, latch_rb;

	logic [CW-1:0] live_dec, tomb_inc;
	logic [CW+2:0] fill4;
	logic [CW+1:0] live4;
	logic          need_rebuild, too_full, compact;
	logic          last_bank_slot;

	assign hkey = (state_q == lpht_pkg::S_RB_HASH) ? rb_key_q : key_q;

	lpht_hash #(.AW(AW)) u_hash (
		.clk  (clk),
		.key  (hkey),
		.home (home)
	);

	lpht_mem #(.AW(AW + 1)) u_mem (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_val  (rd_val),
		.rd_mark (rd_mark),
		.we      (we),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_val  (wr_val),
		.wr_mark (wr_mark)
	);

	// load tests against the slot count
	assign fill4 = {(CW + 1)'(live_q) + (CW + 1)'(tomb_q), 2'b00};
	assign live4 = {live_q, 2'b00};
	assign need_rebuild = fill4 >= (CW + 3)'(THREE_Q);
	assign too_full = live4 >= (CW + 2)'(THREE_Q);
	assign live_dec = (live_q != '0) ? live_q - 1'b1 : live_q;
	assign tomb_inc = tomb_q + 1'b1;
	assign compact = CAN_COMPACT &&
		({tomb_inc, 3'b000} >= (CW + 3)'(TABLE_SLOTS)) &&
		({live_dec, 1'b0} < (CW + 1)'(TABLE_SLOTS));
	assign last_bank_slot = cnt_q[AW-1:0] == {AW{1'b1}};

	always_comb begin
		state_d      = state_q;
		slot_d       = slot_q;
		tomb_slot_d  = tomb_slot_q;
		where_d      = where_q;
		n_d          = n_q;
		have_tomb_d  = have_tomb_q;
		found_d      = found_q;
		room_d       = room_q;
		bank_d       = bank_q;
		rb_ret_d     = rb_ret_q;
		cnt_d        = cnt_q;
		live_d       = live_q;
		tomb_d       = tomb_q;
		res_status_d = res_status_q;
		res_rv_d     = res_rv_q;
		load_out     = 1'b0;
		latch_cmd    = 1'b0;
		latch_rb     = 1'b0;
		s_tready     = 1'b0;
		rd_addr      = {bank_q, slot_q};
		wr_addr      = {bank_q, where_q};
		wr_key       = key_q;
		wr_val       = val_q;
		wr_mark      = lpht_pkg::MARK_USED;
		we           = '0;

		case (state_q)
			lpht_pkg::S_INIT: begin
				// empty every mark of both banks
				wr_addr = cnt_q;
				wr_mark = lpht_pkg::MARK_EMPTY;
				we.mark = 1'b1;
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == {(AW + 1){1'b1}}) begin
					state_d = lpht_pkg::S_IDLE;
				end
			end
			lpht_pkg::S_IDLE: begin
				s_tready     = 1'b1;
				res_status_d = lpht_pkg::ST_OK;
				res_rv_d     = '0;
				found_d      = 1'b0;
				cnt_d        = '0;
				if (s_tvalid) begin
					latch_cmd = 1'b1;
					if (s_tuser == lpht_pkg::CMD_CLEAR) begin
						state_d = lpht_pkg::S_CLR;
					end else if (s_tuser == lpht_pkg::CMD_SET && need_rebuild) begin
						rb_ret_d = 1'b1;
						state_d  = lpht_pkg::S_RB_CLR;
					end else begin
						state_d = lpht_pkg::S_HASH;
					end
				end
			end
			lpht_pkg::S_HASH: begin
				state_d = lpht_pkg::S_HOME;
			end
			lpht_pkg::S_HOME: begin
				slot_d      = home;
				n_d         = '0;
				have_tomb_d = 1'b0;
				state_d     = lpht_pkg::S_PRD;
			end
			lpht_pkg::S_PRD: begin
				rd_addr = {bank_q, slot_q};
				state_d = lpht_pkg::S_PCHK;
			end
			lpht_pkg::S_PCHK: begin
				if (rd_mark == lpht_pkg::MARK_EMPTY) begin
					where_d = have_tomb_q ? tomb_slot_q : slot_q;
					room_d  = 1'b1;
					found_d = 1'b0;
					state_d = lpht_pkg::S_ACT;
				end else if (rd_mark == lpht_pkg::MARK_USED && rd_key == key_q) begin
					where_d  = slot_q;
					room_d   = 1'b1;
					found_d  = 1'b1;
					res_rv_d = rd_val;
					state_d  = lpht_pkg::S_ACT;
				end else begin
					// tombstone or other key: remember the first tombstone, advance
					if (rd_mark != lpht_pkg::MARK_USED && !have_tomb_q) begin
						have_tomb_d = 1'b1;
						tomb_slot_d = slot_q;
					end
					slot_d = slot_q + 1'b1;
					n_d    = n_q + 1'b1;
					if (n_q == {AW{1'b1}}) begin
						where_d = tomb_slot_d;
						room_d  = have_tomb_d;
						found_d = 1'b0;
						state_d = lpht_pkg::S_ACT;
					end else begin
						state_d = lpht_pkg::S_PRD;
					end
				end
			end
			lpht_pkg::S_ACT: begin
				state_d = lpht_pkg::S_DONE;
				case (cmd_q)
					lpht_pkg::CMD_SET: begin
						res_rv_d = '0;
						if (found_q) begin
							we.val = 1'b1;
						end else if (too_full || !room_q) begin
							res_status_d = lpht_pkg::ST_FULL;
						end else begin
							// a reused slot on this path is always a tombstone
							if (have_tomb_q && tomb_q != '0) begin
								tomb_d = tomb_q - 1'b1;
							end
							we     = '{key: 1'b1, val: 1'b1, mark: 1'b1};
							live_d = live_q + 1'b1;
						end
					end
					lpht_pkg::CMD_GET: begin
						if (!found_q) begin
							res_status_d = lpht_pkg::ST_ABSENT;
							res_rv_d     = '0;
						end
					end
					lpht_pkg::CMD_REMOVE: begin
						res_rv_d = '0;
						if (found_q) begin
							wr_mark = lpht_pkg::MARK_TOMB;
							wr_val  = '0;
							we      = '{key: 1'b0, val: 1'b1, mark: 1'b1};
							live_d  = live_dec;
							tomb_d  = tomb_inc;
							if (compact) begin
								rb_ret_d = 1'b0;
								cnt_d    = '0;
								state_d  = lpht_pkg::S_RB_CLR;
							end
						end else begin
							res_status_d = lpht_pkg::ST_ABSENT;
						end
					end
					default: begin
						res_rv_d = '0;
					end
				endcase
			end
			lpht_pkg::S_CLR: begin
				wr_addr = {bank_q, cnt_q[AW-1:0]};
				wr_mark = lpht_pkg::MARK_EMPTY;
				we.mark = 1'b1;
				cnt_d   = cnt_q + 1'b1;
				if (last_bank_slot) begin
					live_d  = '0;
					tomb_d  = '0;
					state_d = lpht_pkg::S_DONE;
				end
			end
			lpht_pkg::S_RB_CLR: begin
				// empty the spare bank
				wr_addr = {~bank_q, cnt_q[AW-1:0]};
				wr_mark = lpht_pkg::MARK_EMPTY;
				we.mark = 1'b1;
				cnt_d   = cnt_q + 1'b1;
				if (last_bank_slot) begin
					cnt_d   = '0;
					state_d = lpht_pkg::S_RB_RD;
				end
			end
			lpht_pkg::S_RB_RD: begin
				rd_addr = {bank_q, cnt_q[AW-1:0]};
				state_d = lpht_pkg::S_RB_CHK;
			end
			lpht_pkg::S_RB_CHK: begin
				if (rd_mark == lpht_pkg::MARK_USED) begin
					latch_rb = 1'b1;
					state_d  = lpht_pkg::S_RB_HASH;
				end else begin
					cnt_d = cnt_q + 1'b1;
					if (last_bank_slot) begin
						bank_d  = ~bank_q;
						tomb_d  = '0;
						state_d = rb_ret_q ? lpht_pkg::S_HASH : lpht_pkg::S_DONE;
					end else begin
						state_d = lpht_pkg::S_RB_RD;
					end
				end
			end
			lpht_pkg::S_RB_HASH: begin
				state_d = lpht_pkg::S_RB_HOME;
			end
			lpht_pkg::S_RB_HOME: begin
				slot_d  = home;
				n_d     = '0;
				state_d = lpht_pkg::S_RB_PRD;
			end
			lpht_pkg::S_RB_PRD: begin
				rd_addr = {~bank_q, slot_q};
				state_d = lpht_pkg::S_RB_PCHK;
			end
			lpht_pkg::S_RB_PCHK: begin
				if (rd_mark == lpht_pkg::MARK_USED) begin
					slot_d = slot_q + 1'b1;
					n_d    = n_q + 1'b1;
					state_d = (n_q == {AW{1'b1}}) ? lpht_pkg::S_RB_WR : lpht_pkg::S_RB_PRD;
				end else begin
					state_d = lpht_pkg::S_RB_WR;
				end
			end
			lpht_pkg::S_RB_WR: begin
				wr_addr = {~bank_q, slot_q};
				wr_key  = rb_key_q;
				wr_val  = rb_val_q;
				wr_mark = lpht_pkg::MARK_USED;
				we      = '{key: 1'b1, val: 1'b1, mark: 1'b1};
				cnt_d   = cnt_q + 1'b1;
				if (last_bank_slot) begin
					bank_d  = ~bank_q;
					tomb_d  = '0;
					state_d = rb_ret_q ? lpht_pkg::S_HASH : lpht_pkg::S_DONE;
				end else begin
					state_d = lpht_pkg::S_RB_RD;
				end
			end
			lpht_pkg::S_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = lpht_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lpht_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lpht_pkg::S_INIT;
			cnt_q        <= '0;
			bank_q       <= 1'b0;
			live_q       <= '0;
			tomb_q       <= '0;
			rb_ret_q     <= 1'b0;
			have_tomb_q  <= 1'b0;
			found_q      <= 1'b0;
			room_q       <= 1'b0;
			n_q          <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			bank_q      <= bank_d;
			live_q      <= live_d;
			tomb_q      <= tomb_d;
			rb_ret_q    <= rb_ret_d;
			have_tomb_q <= have_tomb_d;
			found_q     <= found_d;
			room_q      <= room_d;
			n_q         <= n_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		slot_q       <= slot_d;
		tomb_slot_q  <= tomb_slot_d;
		where_q      <= where_d;
		res_status_q <= res_status_d;
		res_rv_q     <= res_rv_d;
		res_found_q  <= found_d;
		if (latch_cmd) begin
			cmd_q <= s_tuser;
			key_q <= s_tdata[31:0];
			val_q <= s_tdata[63:32];
		end
		if (latch_rb) begin
			rb_key_q <= rd_key;
			rb_val_q <= rd_val;
		end
		if (load_out) begin
			out_data_q <= {2'b00, lpht_pkg::COUNT_W'(live_q), res_rv_q,
				res_found_q && (cmd_q != lpht_pkg::CMD_CLEAR), res_status_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// the live count never exceeds the slot count
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CW'(TABLE_SLOTS))
		else $error("live count above slot count");

	// a command is taken only from idle, and work starts at once
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("accepted a second command without working the first");

	// a refused insert never reports the key as found
	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[1:0] == lpht_pkg::ST_FULL && m_tdata[2]))
		else $error("full status with found flag");

	// the bank flips only when a rebuild finishes, which clears the tombstones
	a_bank_flip: assert property (@(posedge clk) disable iff (!arst_n)
		bank_q != $past(bank_q) |-> tomb_q == '0)
		else $error("bank flip without tombstone reset");

endmodule

// File: rtl/lpht_hash.sv
// ----------------------------------------------------------------------------
// lpht_hash: home slot of a key
// Multiplies the key by the golden-ratio constant and registers the low bits.
// ----------------------------------------------------------------------------
module lpht_hash #(
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic [31:0]   key,
	output logic [AW-1:0] home
);
	logic [31:0] prod;

	assign prod = 32'(key * lpht_pkg::FIB_MUL);

	always_ff @(posedge clk) begin
		home <= prod[AW-1:0];
	end
endmodule

// File: rtl/lpht_mem.sv
// ----------------------------------------------------------------------------
// lpht_mem: slot storage for both banks
// Key, value and mark arrays, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lpht_mem #(
	parameter int AW = 11
) (
	input  logic              clk,
	input  logic [AW-1:0]     rd_addr,
	output logic [31:0]       rd_key,
	output logic [31:0]       rd_val,
	output logic [1:0]        rd_mark,
	input  lpht_pkg::mem_we_t we,
	input  logic [AW-1:0]     wr_addr,
	input  logic [31:0]       wr_key,
	input  logic [31:0]       wr_val,
	input  logic [1:0]        wr_mark
);
	localparam int DEPTH = 1 << AW;

	logic [31:0] key_mem  [DEPTH];
	logic [31:0] val_mem  [DEPTH];
	logic [1:0]  mark_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we.key) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (we.val) begin
			val_mem[wr_addr] <= wr_val;
		end
		if (we.mark) begin
			mark_mem[wr_addr] <= wr_mark;
		end
		rd_key  <= key_mem[rd_addr];
		rd_val  <= val_mem[rd_addr];
		rd_mark <= mark_mem[rd_addr];
	end
endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the linear probe hash table unit
// Drives set, get, remove and clear beats with random gaps, predicts every
// result with a behavioral copy of the two-bank table, and checks each
// result beat field by field in order.
// ----------------------------------------------------------------------------

class table_scoreboard;
	localparam int SLOTS = 1024;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [31:0] read_value;
		logic [10:0] entry_count;
	} result_t;

	logic [31:0] keys [2*SLOTS];
	logic [31:0] vals [2*SLOTS];
	logic [1:0]  marks [2*SLOTS];
	int unsigned bank, live, tombs;
	result_t pending [$];
	int errors;
	int sets, gets, removes, clears, fulls, rebuilds;

	function new();
		for (int i = 0; i < 2*SLOTS; i++) begin
			keys[i] = '0;
			vals[i] = '0;
			marks[i] = lpht_pkg::MARK_EMPTY;
		end
		bank = 0;
		live = 0;
		tombs = 0;
		errors = 0;
	endfunction

	function int unsigned home_of(logic [31:0] k);
		logic [31:0] h;
		h = k * lpht_pkg::FIB_MUL;
		return h % SLOTS;
	endfunction

	// Probe the active bank; returns 1 when present, else 0 and gives the insert slot.
	function bit probe(logic [31:0] k, output int unsigned where, output bit room);
		int unsigned b, s, tomb;
		bit have_tomb;
		b = bank * SLOTS;
		s = home_of(k);
		have_tomb = 0;
		tomb = 0;
		for (int n = 0; n < SLOTS; n++) begin
			if (marks[b+s] == lpht_pkg::MARK_EMPTY) begin
				where = have_tomb ? tomb : s;
				room = 1;
				return 0;
			end
			if (marks[b+s] == lpht_pkg::MARK_USED) begin
				if (keys[b+s] == k) begin
					where = s;
					room = 1;
					return 1;
				end
			end else if (!have_tomb) begin
				have_tomb = 1;
				tomb = s;
			end
			s = (s + 1) % SLOTS;
		end
		where = tomb;
		room = have_tomb;
		return 0;
	endfunction

	// Copy live entries in slot order into the spare bank and switch to it.
	function void compact();
		int unsigned src, dst, s, n;
		src = bank * SLOTS;
		dst = (bank ^ 1) * SLOTS;
		for (int i = 0; i < SLOTS; i++) marks[dst+i] = lpht_pkg::MARK_EMPTY;
		for (int i = 0; i < SLOTS; i++) begin
			if (marks[src+i] != lpht_pkg::MARK_USED) continue;
			s = home_of(keys[src+i]);
			for (n = 0; n < SLOTS && marks[dst+s] == lpht_pkg::MARK_USED; n++)
				s = (s + 1) % SLOTS;
			keys[dst+s] = keys[src+i];
			vals[dst+s] = vals[src+i];
			marks[dst+s] = lpht_pkg::MARK_USED;
		end
		bank ^= 1;
		tombs = 0;
		rebuilds++;
	endfunction

	function void note_command(logic [1:0] cmd, logic [31:0] k, logic [31:0] v);
		result_t r;
		int unsigned slot, b;
		bit room, hit;
		r = '0;
		case (cmd)
			lpht_pkg::CMD_SET: begin
				sets++;
				if ((live + tombs) * 4 >= SLOTS * 3) compact();
				b = bank * SLOTS;
				hit = probe(k, slot, room);
				if (hit) begin
					vals[b+slot] = v;
					r.found = 1;
				end else if (live * 4 >= SLOTS * 3 || !room) begin
					r.status = lpht_pkg::ST_FULL;
					fulls++;
				end else begin
					if (marks[b+slot] != lpht_pkg::MARK_EMPTY && tombs > 0) tombs--;
					keys[b+slot] = k;
					vals[b+slot] = v;
					marks[b+slot] = lpht_pkg::MARK_USED;
					live++;
				end
			end
			lpht_pkg::CMD_GET: begin
				gets++;
				b = bank * SLOTS;
				if (probe(k, slot, room)) begin
					r.found = 1;
					r.read_value = vals[b+slot];
				end else r.status = lpht_pkg::ST_ABSENT;
			end
			lpht_pkg::CMD_REMOVE: begin
				removes++;
				b = bank * SLOTS;
				if (probe(k, slot, room)) begin
					r.found = 1;
					marks[b+slot] = lpht_pkg::MARK_TOMB;
					vals[b+slot] = '0;
					if (live > 0) live--;
					tombs++;
					if (tombs * 8 >= SLOTS && live * 2 < SLOTS &&
						SLOTS > lpht_pkg::MIN_COMPACT_SLOTS)
						compact();
				end else r.status = lpht_pkg::ST_ABSENT;
			end
			default: begin
				clears++;
				b = bank * SLOTS;
				for (int i = 0; i < SLOTS; i++) marks[b+i] = lpht_pkg::MARK_EMPTY;
				live = 0;
				tombs = 0;
			end
		endcase
		r.entry_count = live[10:0];
		pending.push_back(r);
	endfunction

	function void check_result(logic [47:0] d);
		result_t e;
		if (pending.size() == 0) begin
			$error("result beat with nothing expected: %h", d);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (d[1:0] !== e.status) begin
			$error("status exp %0d got %0d", e.status, d[1:0]);
			errors++;
		end
		if (d[2] !== e.found) begin
			$error("found exp %0d got %0d", e.found, d[2]);
			errors++;
		end
		if (d[34:3] !== e.read_value) begin
			$error("read_value exp %h got %h", e.read_value, d[34:3]);
			errors++;
		end
		if (d[45:35] !== e.entry_count) begin
			$error("entry_count exp %0d got %0d", e.entry_count, d[45:35]);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam int WATCHDOG = 200000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;  // key [31:0], value [63:32]
	logic [1:0]  s_tuser = '0;  // cmd [1:0]
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [47:0] m_tdata;       // status, found, read_value, entry_count

	table_scoreboard sb;
	bit stall_long = 0;      // receiver hold-off request
	int idle_cycles = 0;
	bit timed_out = 0;

	// Pool of keys already used so gets and removes mostly hit.
	logic [31:0] used_keys [$];

	linear_probe_hash_table_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
	endfunction

	// Offer one beat and hold it until accepted; note it in the scoreboard.
	task automatic send_cmd(logic [1:0] cmd, logic [31:0] k, logic [31:0] v);
		s_tvalid <= 1;
		s_tuser <= cmd;
		s_tdata <= {v, k};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_command(cmd, k, v);
		if (cmd == lpht_pkg::CMD_SET) used_keys.push_back(k);
	endtask

	// Drop valid after the beat, then wait the given gap (nothing when it is zero).
	task automatic pause_between(int n);
		if (n > 0) begin
			s_tvalid <= 0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_key();
		if (used_keys.size() != 0 && $urandom_range(0, 3) != 0)
			return used_keys[$urandom_range(0, used_keys.size() - 1)];
		return $urandom();
	endfunction

	// Receiver: random tready, with one long hold-off on request.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (stall_long) begin
				m_tready <= 0;
				repeat (400) @(posedge clk);
				stall_long = 0;
			end
			n = gap_len();
			if (n > 0 && $urandom_range(0, 2) == 0) begin
				m_tready <= 0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
		end
	end

	// Check every result beat at the edge it is accepted.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
	end

	// Watchdog: count cycles with no beat on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG && !timed_out) begin
			timed_out = 1;
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		logic [31:0] k;
		int r;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, every command, special cases.
		send_cmd(lpht_pkg::CMD_GET, 32'h0, 32'h0);            // absent get on empty table
		send_cmd(lpht_pkg::CMD_SET, 32'h0, 32'hFFFF_FFFF);
		send_cmd(lpht_pkg::CMD_SET, 32'hFFFF_FFFF, 32'h0);
		send_cmd(lpht_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0);
		send_cmd(lpht_pkg::CMD_GET, 32'h0, 32'h1234_5678);
		send_cmd(lpht_pkg::CMD_SET, 32'h0, 32'hA5A5_5A5A);    // replace present key
		send_cmd(lpht_pkg::CMD_GET, 32'h0, 32'h0);
		send_cmd(lpht_pkg::CMD_REMOVE, 32'h0, 32'hFFFF_FFFF);
		send_cmd(lpht_pkg::CMD_REMOVE, 32'h0, 32'h0);         // absent remove
		send_cmd(lpht_pkg::CMD_SET, 32'h0, 32'h5555_AAAA);    // reuse tombstone
		send_cmd(lpht_pkg::CMD_SET, 32'h0000_0400, 32'hAAAA_5555);
		send_cmd(lpht_pkg::CMD_GET, 32'h0000_0400, 32'h0);
		send_cmd(lpht_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_cmd(lpht_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0);    // gone after clear
		pause_between(1);
		used_keys.delete();

		// Pressure: receiver holds off while the sender keeps offering.
		stall_long = 1;
		for (int i = 0; i < 20; i++) send_cmd(lpht_pkg::CMD_SET, $urandom(), $urandom());
		drain_results();

		// Fill part of the table.
		for (int i = 0; i < 150; i++) begin
			send_cmd(lpht_pkg::CMD_SET, $urandom(), $urandom());
			pause_between($urandom_range(0, 7) == 0 ? gap_len() : 0);
		end
		// Remove enough keys to leave an eighth of the slots as tombstones,
		// which drives the compaction after remove.
		for (int i = 0; i < 130 && used_keys.size() != 0; i++) begin
			r = $urandom_range(0, used_keys.size() - 1);
			k = used_keys[r];
			used_keys.delete(r);
			send_cmd(lpht_pkg::CMD_REMOVE, k, $urandom());
			pause_between($urandom_range(0, 7) == 0 ? gap_len() : 0);
		end
		drain_results();

		// Random mix.
		for (int i = 0; i < 140; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45) send_cmd(lpht_pkg::CMD_SET, pick_key(), $urandom());
			else if (r < 75) send_cmd(lpht_pkg::CMD_GET, pick_key(), $urandom());
			else if (r < 98) send_cmd(lpht_pkg::CMD_REMOVE, pick_key(), $urandom());
			else begin
				send_cmd(lpht_pkg::CMD_CLEAR, $urandom(), $urandom());
				used_keys.delete();
			end
			pause_between(gap_len());
		end

		drain_results();
		repeat (3000) @(posedge clk);
		$display("Covered %0d sets, %0d gets, %0d removes, %0d clears;",
			sb.sets, sb.gets, sb.removes, sb.clears);
		$display("%0d inserts refused, %0d rebuilds predicted.", sb.fulls, sb.rebuilds);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
